### rtl/gbn_pkg.sv
// Shared types and constants of the go-back-N sender.
package gbn_pkg;

  // Sequence number width and buffer sizing
  localparam int SEQ_W      = 16;
  localparam int WSIZE_W    = 6;
  localparam int BUF_DEPTH  = 1024;
  localparam int WINDOW_MAX = 32;

  // Stored messages allowed: buffer depth, or one less than the number space
  localparam longint SEQ_SPAN = longint'(1) << SEQ_W;
  localparam longint CAPACITY = (BUF_DEPTH < SEQ_SPAN - 1) ? BUF_DEPTH : SEQ_SPAN - 1;

  // Input stream packing
  localparam int IN_DATA_W = 24;
  localparam int OP_W      = 2;
  localparam int ACT_W     = 3;

  typedef logic [SEQ_W-1:0] seq_t;

  typedef enum logic [OP_W-1:0] {
    OP_NEW = 2'd0,
    OP_ACK = 2'd1,
    OP_EXP = 2'd2
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_TX      = 3'd0,
    ACT_START   = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_QUEUED  = 3'd3,
    ACT_REFUSED = 3'd4,
    ACT_IGNORED = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEW_CHK,
    ST_NEW_WIN,
    ST_NEW_TX,
    ST_ACK_FL,
    ST_ACK_CHK,
    ST_ACK_RST,
    ST_ACK_LOOP,
    ST_ACK_TST,
    ST_EXP,
    ST_EXP_LOOP,
    ST_DONE
  } state_t;

endpackage

### rtl/go_back_n_sender.sv
// Go-back-N sender control: sequencer around one shared subtract/compare unit.
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser op, tdata ack_num, ack_ok
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser action, tdata seq_num, tlast
//  cfg      | in  | cfg_valid/cfg_ready          | cfg_data window setting
//
// One item per event; s_axis_tready is high only while the sequencer is idle.
// Results pass a one-deep hold stage and the output register; a stalled m_axis freezes
// the sequencer. Synchronous reset clears pointers to zero and the window setting to 8.
module go_back_n_sender (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [gbn_pkg::IN_DATA_W-1:0] s_axis_tdata,  // [15:0] ack_num, [16] ack_ok
  input  logic [gbn_pkg::OP_W-1:0]    s_axis_tuser,  // [1:0] op
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [gbn_pkg::SEQ_W-1:0]   m_axis_tdata,  // [15:0] seq_num
  output logic [gbn_pkg::ACT_W-1:0]   m_axis_tuser,  // [2:0] action
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gbn_pkg::WSIZE_W-1:0] cfg_data
);
  import gbn_pkg::*;

  // Registers
  state_t               state, state_next;
  logic [WSIZE_W-1:0]   win_setting;
  seq_t                 window_base, window_base_next;
  seq_t                 next_unsent, next_unsent_next;
  seq_t                 next_free, next_free_next;
  seq_t                 cur_seq, cur_seq_next;
  seq_t                 flight, flight_next;
  seq_t                 ack_r, ack_r_next;
  logic                 ok_r, ok_r_next;
  logic                 pend_valid, pend_valid_next;
  action_t              pend_action, pend_action_next;
  seq_t                 pend_seq, pend_seq_next;
  logic                 out_valid, out_valid_next;
  action_t              out_action, out_action_next;
  seq_t                 out_seq, out_seq_next;
  logic                 out_last, out_last_next;

  // Control
  logic                 adv;
  logic                 accept;
  logic                 do_emit;
  action_t              emit_act;
  seq_t                 emit_seq;
  logic                 do_finish;
  logic [WSIZE_W-1:0]   win;
  seq_t                 alu_a, alu_lim, alu_diff;
  logic                 alu_lt;

  assign adv           = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_seq;
  assign m_axis_tuser  = out_action;
  assign m_axis_tlast  = out_last;

  // Effective window, clamped to 1..WINDOW_MAX
  always_comb begin
    if (win_setting == '0) begin
      win = WSIZE_W'(1);
    end else if (win_setting > WSIZE_W'(WINDOW_MAX)) begin
      win = WSIZE_W'(WINDOW_MAX);
    end else begin
      win = win_setting;
    end
  end

  // Shared unit: distance from the window base, compared with a limit
  always_comb begin
    unique case (state)
      ST_NEW_CHK: alu_a = next_free;
      ST_NEW_WIN: alu_a = cur_seq;
      ST_ACK_CHK: alu_a = ack_r;
      default:    alu_a = next_unsent;
    endcase
    unique case (state)
      ST_NEW_CHK: alu_lim = SEQ_W'(CAPACITY);
      ST_ACK_CHK: alu_lim = flight;
      default:    alu_lim = SEQ_W'(win);
    endcase
    alu_diff = alu_a - window_base;
    alu_lt   = alu_diff < alu_lim;
  end

  // Sequencer: next state, pointer updates and result requests
  always_comb begin
    state_next       = state;
    window_base_next = window_base;
    next_unsent_next = next_unsent;
    next_free_next   = next_free;
    cur_seq_next     = cur_seq;
    flight_next      = flight;
    ack_r_next       = ack_r;
    ok_r_next        = ok_r;
    do_emit          = 1'b0;
    emit_act         = ACT_TX;
    emit_seq         = '0;
    do_finish        = 1'b0;

    if (state == ST_IDLE) begin
      if (accept) begin
        ack_r_next = s_axis_tdata[SEQ_W-1:0];
        ok_r_next  = s_axis_tdata[SEQ_W];
        unique case (s_axis_tuser)
          OP_NEW:  state_next = ST_NEW_CHK;
          OP_ACK:  state_next = ST_ACK_FL;
          OP_EXP:  state_next = ST_EXP;
          default: state_next = ST_DONE;
        endcase
      end
    end else if (adv) begin
      unique case (state)
        // New message: room in the buffer?
        ST_NEW_CHK: begin
          if (!alu_lt) begin
            do_emit    = 1'b1;
            emit_act   = ACT_REFUSED;
            emit_seq   = next_free;
            state_next = ST_DONE;
          end else begin
            cur_seq_next   = next_free;
            next_free_next = next_free + SEQ_W'(1);
            state_next     = ST_NEW_WIN;
          end
        end
        // Send now if it is next in line and inside the window
        ST_NEW_WIN: begin
          do_emit = 1'b1;
          if (next_unsent == cur_seq && alu_lt) begin
            if (cur_seq == window_base) begin
              emit_act   = ACT_START;
              state_next = ST_NEW_TX;
            end else begin
              emit_act         = ACT_TX;
              emit_seq         = cur_seq;
              next_unsent_next = next_unsent + SEQ_W'(1);
              state_next       = ST_DONE;
            end
          end else begin
            emit_act   = ACT_QUEUED;
            emit_seq   = cur_seq;
            state_next = ST_DONE;
          end
        end
        ST_NEW_TX: begin
          do_emit          = 1'b1;
          emit_act         = ACT_TX;
          emit_seq         = cur_seq;
          next_unsent_next = next_unsent + SEQ_W'(1);
          state_next       = ST_DONE;
        end
        // Acknowledgement: packets in flight first
        ST_ACK_FL: begin
          flight_next = alu_diff;
          state_next  = ST_ACK_CHK;
        end
        ST_ACK_CHK: begin
          do_emit = 1'b1;
          if (!ok_r || !alu_lt) begin
            emit_act   = ACT_IGNORED;
            emit_seq   = ack_r;
            state_next = ST_DONE;
          end else begin
            window_base_next = ack_r + SEQ_W'(1);
            emit_act         = ACT_STOP;
            state_next       = ST_ACK_RST;
          end
        end
        ST_ACK_RST: begin
          if (window_base != next_unsent) begin
            do_emit  = 1'b1;
            emit_act = ACT_START;
          end
          state_next = ST_ACK_LOOP;
        end
        // Send queued packets that now fit the window
        ST_ACK_LOOP: begin
          if (next_unsent != next_free && alu_lt) begin
            do_emit  = 1'b1;
            emit_act = ACT_TX;
            emit_seq = next_unsent;
            if (next_unsent == window_base) begin
              state_next = ST_ACK_TST;
            end else begin
              next_unsent_next = next_unsent + SEQ_W'(1);
            end
          end else begin
            state_next = ST_DONE;
          end
        end
        ST_ACK_TST: begin
          do_emit          = 1'b1;
          emit_act         = ACT_START;
          next_unsent_next = next_unsent + SEQ_W'(1);
          state_next       = ST_ACK_LOOP;
        end
        // Expiry: resend everything in flight
        ST_EXP: begin
          cur_seq_next = window_base;
          state_next   = (next_unsent == window_base) ? ST_DONE : ST_EXP_LOOP;
        end
        ST_EXP_LOOP: begin
          do_emit = 1'b1;
          if (cur_seq != next_unsent) begin
            emit_act     = ACT_TX;
            emit_seq     = cur_seq;
            cur_seq_next = cur_seq + SEQ_W'(1);
          end else begin
            emit_act   = ACT_START;
            state_next = ST_DONE;
          end
        end
        ST_DONE: begin
          do_finish  = 1'b1;
          state_next = ST_IDLE;
        end
        default: state_next = ST_IDLE;
      endcase
    end
  end

  // One result held back so the final one can be marked last
  always_comb begin
    pend_valid_next  = pend_valid;
    pend_action_next = pend_action;
    pend_seq_next    = pend_seq;
    out_valid_next   = out_valid && !m_axis_tready;
    out_action_next  = out_action;
    out_seq_next     = out_seq;
    out_last_next    = out_last;
    if (do_emit) begin
      pend_valid_next  = 1'b1;
      pend_action_next = emit_act;
      pend_seq_next    = emit_seq;
    end else if (do_finish) begin
      pend_valid_next = 1'b0;
    end
    if ((do_emit || do_finish) && pend_valid) begin
      out_valid_next  = 1'b1;
      out_action_next = pend_action;
      out_seq_next    = pend_seq;
      out_last_next   = do_finish;
    end
  end

  // Control and pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      win_setting <= WSIZE_W'(8);
      window_base <= '0;
      next_unsent <= '0;
      next_free   <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      if (cfg_valid && cfg_ready) begin
        win_setting <= cfg_data;
      end
      window_base <= window_base_next;
      next_unsent <= next_unsent_next;
      next_free   <= next_free_next;
      pend_valid  <= pend_valid_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_seq     <= cur_seq_next;
    flight      <= flight_next;
    ack_r       <= ack_r_next;
    ok_r        <= ok_r_next;
    pend_action <= pend_action_next;
    pend_seq    <= pend_seq_next;
    out_action  <= out_action_next;
    out_seq     <= out_seq_next;
    out_last    <= out_last_next;
  end

endmodule

### rtl/gbn_checker.sv
// Port-level checks for the go-back-N sender, bound to the top level.
module gbn_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [gbn_pkg::SEQ_W-1:0]  m_axis_tdata,
  input logic [gbn_pkg::ACT_W-1:0]  m_axis_tuser,
  input logic                       m_axis_tlast
);
  import gbn_pkg::*;

  // Sequencer is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while sequencer busy");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Timer actions carry no sequence number
  a_timer_seq_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ACT_START || m_axis_tuser == ACT_STOP)
      |-> m_axis_tdata == '0)
    else $error("timer action with nonzero sequence number");

  // Queued, refused and ignored are always the only result of their item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ACT_QUEUED || m_axis_tuser == ACT_REFUSED ||
      m_axis_tuser == ACT_IGNORED) |-> m_axis_tlast)
    else $error("sole result not marked last");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### sim/testbench.sv
// Self-checking testbench for the go-back-N sender: shadow model, stream drivers, action checks.
module testbench;
  import gbn_pkg::*;

  localparam int          CLK_HALF       = 10;
  localparam int unsigned BUF_SLOTS      = int'(CAPACITY);
  localparam int unsigned WINDOW_CAP     = WINDOW_MAX;
  localparam int unsigned RESET_WINDOW   = 8;
  localparam int          SETTLE_CYCLES  = 48;
  localparam int          HOLD_CYCLES    = 600;
  localparam int          STALL_ITEMS    = 40;
  localparam int          RANDOM_ITEMS   = 82;
  localparam longint      RUN_LIMIT      = 64'd60_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  // One expected action of the sender
  typedef struct packed {
    action_t act;
    seq_t    seq;
    logic    last;
  } action_item_t;

  // Shadow copy of the sender state; predicts the actions of each accepted item
  class sender_shadow;
    logic [WSIZE_W-1:0] win_setting;
    seq_t               window_base;
    seq_t               next_unsent;
    seq_t               next_free;
    bit                 timer_running;
    action_item_t       pending_actions[$];
    action_item_t       burst[$];
    int unsigned        events;
    int unsigned        checked;
    int unsigned        refusals;
    int unsigned        ignored_acks;
    int unsigned        longest_burst;
    int unsigned        mismatches;

    function new();
      win_setting = WSIZE_W'(RESET_WINDOW);
      window_base = '0;
      next_unsent = '0;
      next_free = '0;
      timer_running = 1'b0;
    endfunction

    function void emit(action_t act, seq_t seq);
      action_item_t it;
      it.act = act;
      it.seq = seq;
      it.last = 1'b0;
      burst = {burst, it};
      if (act == ACT_START) timer_running = 1'b1;
    endfunction

    function void note_event(logic [OP_W-1:0] op, seq_t ack, logic ok);
      seq_t        gap;
      seq_t        seq;
      seq_t        s;
      int unsigned win;
      win = (win_setting == 0) ? 1 :
            (win_setting > WINDOW_CAP) ? WINDOW_CAP : int'(win_setting);
      burst.delete();
      events++;
      case (op)
        OP_NEW: begin
          gap = next_free - window_base;
          if (gap >= BUF_SLOTS) begin
            emit(ACT_REFUSED, next_free);
            refusals++;
          end else begin
            seq = next_free;
            next_free = next_free + 1'b1;
            gap = seq - window_base;
            if (next_unsent == seq && gap < win) begin
              if (seq == window_base) emit(ACT_START, '0);
              emit(ACT_TX, seq);
              next_unsent = next_unsent + 1'b1;
            end else begin
              emit(ACT_QUEUED, seq);
            end
          end
        end
        OP_ACK: begin
          gap = next_unsent - window_base;
          seq = ack - window_base;
          // bad checksum, or nothing in flight at that number
          if (!ok || seq >= gap) begin
            emit(ACT_IGNORED, ack);
            ignored_acks++;
          end else begin
            window_base = ack + 1'b1;
            emit(ACT_STOP, '0);
            timer_running = 1'b0;
            if (window_base != next_unsent) emit(ACT_START, '0);
            // release queued messages that now fit the window
            gap = next_unsent - window_base;
            while (next_unsent != next_free && gap < win) begin
              emit(ACT_TX, next_unsent);
              if (next_unsent == window_base) emit(ACT_START, '0);
              next_unsent = next_unsent + 1'b1;
              gap = next_unsent - window_base;
            end
          end
        end
        OP_EXP: begin
          if (next_unsent == window_base) begin
            timer_running = 1'b0;
          end else begin
            for (s = window_base; s != next_unsent; s = s + 1'b1) emit(ACT_TX, s);
            emit(ACT_START, '0);
          end
        end
        default: ;
      endcase
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      if (burst.size() > longest_burst) longest_burst = burst.size();
      pending_actions = {pending_actions, burst};
    endfunction

    function void check_action(action_t act, seq_t seq, logic last);
      action_item_t want;
      checked++;
      if (pending_actions.size() == 0) begin
        $error("unexpected action %0d seq_num %0d last %0b", act, seq, last);
        mismatches++;
        return;
      end
      want = pending_actions.pop_front();
      if (act != want.act) begin
        $error("action: expected %0d, got %0d", want.act, act);
        mismatches++;
      end
      if (seq != want.seq) begin
        $error("seq_num: expected %0d, got %0d", want.seq, seq);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SEQ_W-1:0]     m_axis_tdata;
  logic [ACT_W-1:0]     m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WSIZE_W-1:0]   cfg_data = '0;

  sender_shadow shadow = new();
  int unsigned  snd_idle_pct = 0;
  int unsigned  rcv_idle_pct = 0;
  int unsigned  hold_asked = 0;
  int unsigned  hold_served = 0;

  go_back_n_sender uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] ack_num, [16] ack_ok
    .s_axis_tuser  (s_axis_tuser),   // [1:0] op
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] seq_num
    .m_axis_tuser  (m_axis_tuser),   // [2:0] action
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d actions outstanding", shadow.pending_actions.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      shadow.check_action(action_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
  end

  // Offer one item, with random gaps ahead of it; returns at the falling edge after acceptance
  task automatic push_event(input logic [OP_W-1:0] op, input seq_t ack, input logic ok);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {{(IN_DATA_W-SEQ_W-1){1'b0}}, ok, ack};
    do @(posedge clk); while (!s_axis_tready);
    shadow.note_event(op, ack, ok);
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected action, then let the sequencer finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (shadow.pending_actions.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input logic [WSIZE_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow.win_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(input int unsigned snd, input int unsigned rcv);
    snd_idle_pct = snd;
    rcv_idle_pct <= rcv;
  endtask

  // Acknowledge everything in flight until no message is left waiting
  task automatic drain_backlog();
    while (shadow.next_unsent != shadow.window_base)
      push_event(OP_ACK, shadow.next_unsent - 1'b1, 1'b1);
  endtask

  // Mostly well-formed traffic with random content, some bad acks and unused ops
  task automatic random_event(output bit counted);
    int unsigned     pick;
    seq_t            flight;
    seq_t            ack;
    logic            ok;
    logic [OP_W-1:0] op;
    pick = $urandom_range(99);
    flight = shadow.next_unsent - shadow.window_base;
    ack = seq_t'($urandom);
    ok = 1'($urandom);
    counted = 1'b1;
    if (pick < 45) begin
      op = OP_NEW;
    end else if (pick < 72) begin
      op = OP_ACK;
      ok = 1'b1;
      if (flight != 0)
        ack = shadow.window_base +
              ($urandom_range(1) ? flight - 1'b1 : seq_t'($urandom_range(flight - 1)));
    end else if (pick < 84) begin
      op = OP_EXP;
    end else if (pick < 96) begin
      op = OP_ACK;
      if (flight != 0 && $urandom_range(1)) begin
        ack = shadow.window_base + seq_t'($urandom_range(flight - 1));
        ok = 1'b0;
      end
    end else begin
      op = OP_UNUSED;
      counted = 1'b0;
    end
    push_event(op, ack, ok);
  endtask

  task automatic random_phase(input int n);
    int done;
    bit c;
    done = 0;
    while (done < n) begin
      random_event(c);
      done += c;
    end
  endtask

  // Stimulus
  initial begin
    set_idle(32, 75);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset window of eight: idle events, fill past the window, bad and good acks
    push_event(OP_EXP, 16'h0000, 1'b0);           // expiry with nothing in flight
    push_event(OP_UNUSED, 16'hFFFF, 1'b1);
    push_event(OP_ACK, 16'h0000, 1'b1);           // nothing sent yet
    push_event(OP_NEW, 16'hFFFF, 1'b1);
    repeat (7) push_event(OP_NEW, 16'h0000, 1'b0);
    push_event(OP_NEW, 16'hA5A5, 1'b1);           // beyond the window: queued
    push_event(OP_ACK, 16'h0001, 1'b0);           // checksum failed
    push_event(OP_ACK, 16'hFFFF, 1'b1);           // beyond what was sent
    push_event(OP_ACK, 16'h0002, 1'b1);
    push_event(OP_EXP, 16'hFFFF, 1'b1);
    push_event(OP_ACK, 16'h0008, 1'b1);
    push_event(OP_EXP, 16'h0000, 1'b0);

    // Window of zero clamps to one: queued message sent at the new base
    write_window(6'd0);
    push_event(OP_NEW, 16'h0000, 1'b0);
    push_event(OP_NEW, 16'h0000, 1'b0);
    push_event(OP_NEW, 16'h0000, 1'b0);
    push_event(OP_ACK, 16'h0005, 1'b1);           // stale, below the base
    push_event(OP_ACK, 16'h0009, 1'b1);
    push_event(OP_ACK, 16'h000A, 1'b1);
    push_event(OP_ACK, 16'h000B, 1'b1);

    // Largest window setting clamps to the maximum; new messages keep coming
    // while the receiver holds off, so the block stalls its input
    write_window(6'd63);
    hold_asked++;
    repeat (STALL_ITEMS) push_event(OP_NEW, seq_t'($urandom), 1'($urandom));
    push_event(OP_EXP, seq_t'($urandom), 1'($urandom));
    drain_backlog();

    write_window(6'd2);
    random_phase(RANDOM_ITEMS);

    write_window(6'd32);
    set_idle(75, 32);
    random_phase(RANDOM_ITEMS);

    // No idling on either side
    settle();
    set_idle(0, 0);
    write_window(6'd5);
    random_phase(RANDOM_ITEMS);

    settle();
    $display("Covered %0d items, %0d actions checked; %0d refused, %0d acks ignored.",
             shadow.events, shadow.checked, shadow.refusals, shadow.ignored_acks);
    $display("Windows 0 to 63 with clamping, one long receiver stall, longest burst %0d.",
             shadow.longest_burst);
    if (shadow.mismatches == 0 && shadow.pending_actions.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
